@@ rtl/core/mafhd_pkg.sv @@
// shared types, constants and lookup tables of the mpeg audio frame header decoder
package mafhd_pkg;

	// header layout and limits
	localparam logic [10:0] SYNC_MARK   = 11'h7FF;
	localparam int unsigned L1_SCALE    = 12000;
	localparam int unsigned L23_SCALE   = 144000;
	localparam int unsigned PAYLOAD_MAX = 2047;

	// base sample rates of the rate index, mpeg-1 values
	localparam int unsigned FS_44K1 = 44100;
	localparam int unsigned FS_48K  = 48000;
	localparam int unsigned FS_32K  = 32000;

	// field widths
	localparam int unsigned COEF_W  = 8;
	localparam int unsigned BR_W    = 9;
	localparam int unsigned FS_W    = 16;
	localparam int unsigned SHIFT_W = 2;
	localparam int unsigned PROD_W  = COEF_W + BR_W + 2;
	localparam int unsigned RECIP_SHIFT = 27;
	localparam int unsigned RECIP_W = RECIP_SHIFT;
	localparam int unsigned WIDE_W  = PROD_W + RECIP_W;
	localparam int unsigned QUOT_W  = WIDE_W - RECIP_SHIFT;
	localparam int unsigned LEN_W   = 11;
	localparam int unsigned LSUM_W  = QUOT_W + 3;

	// scale/fs reduced to coef/div per base rate; slot scale is 12000 for layer i
	localparam int unsigned A_L1_44  = L1_SCALE / 300;
	localparam int unsigned D_L1_44  = FS_44K1 / 300;
	localparam int unsigned A_L23_44 = L23_SCALE / 900;
	localparam int unsigned D_L23_44 = FS_44K1 / 900;
	localparam int unsigned A_L1_48  = L1_SCALE / 12000;
	localparam int unsigned D_L1_48  = FS_48K / 12000;
	localparam int unsigned A_L23_48 = 2 * L23_SCALE / FS_48K;
	localparam int unsigned D_L23_48 = 2;
	localparam int unsigned A_L1_32  = L1_SCALE / 4000;
	localparam int unsigned D_L1_32  = FS_32K / 4000;
	localparam int unsigned A_L23_32 = L23_SCALE / 16000;
	localparam int unsigned D_L23_32 = FS_32K / 16000;

	// rounded-up reciprocals, exact for every product the tables can give
	localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;
	localparam longint unsigned R_L1_44  = (RECIP_ONE + D_L1_44 - 1) / D_L1_44;
	localparam longint unsigned R_L23_44 = (RECIP_ONE + D_L23_44 - 1) / D_L23_44;
	localparam longint unsigned R_L1_48  = (RECIP_ONE + D_L1_48 - 1) / D_L1_48;
	localparam longint unsigned R_L23_48 = (RECIP_ONE + D_L23_48 - 1) / D_L23_48;
	localparam longint unsigned R_L1_32  = (RECIP_ONE + D_L1_32 - 1) / D_L1_32;
	localparam longint unsigned R_L23_32 = (RECIP_ONE + D_L23_32 - 1) / D_L23_32;

	// header field codes
	localparam logic [1:0] HV_MPEG1    = 2'b11;
	localparam logic [1:0] HV_MPEG2    = 2'b10;
	localparam logic [1:0] HV_RESERVED = 2'b01;
	localparam logic [1:0] HL_RESERVED = 2'b00;
	localparam logic [1:0] FSI_44      = 2'd0;
	localparam logic [1:0] FSI_48      = 2'd1;
	localparam logic [1:0] FSI_32      = 2'd2;
	localparam logic [1:0] FSI_RESERVED = 2'd3;

	// decoded codes
	localparam logic [1:0] VER_MPEG1  = 2'd0;
	localparam logic [1:0] VER_MPEG2  = 2'd1;
	localparam logic [1:0] VER_MPEG25 = 2'd2;
	localparam logic [1:0] LAYER_I    = 2'd0;
	localparam logic [1:0] LAYER_II   = 2'd1;
	localparam logic [1:0] LAYER_III  = 2'd2;
	localparam logic [1:0] CHMODE_MONO = 2'd3;

	localparam logic [2:0] GRP_V1_L1  = 3'd0;
	localparam logic [2:0] GRP_V1_L2  = 3'd1;
	localparam logic [2:0] GRP_V1_L3  = 3'd2;
	localparam logic [2:0] GRP_V2_L1  = 3'd3;
	localparam logic [2:0] GRP_V2_L23 = 3'd4;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_SYNC     = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BAD_LAYER   = 3'd3,
		ST_BAD_BITRATE = 3'd4,
		ST_BAD_RATE    = 3'd5
	} status_t;

	// decoded header fields that travel down the pipeline
	typedef struct packed {
		status_t           status;
		logic [1:0]        mpeg_version;
		logic [1:0]        layer_index;
		logic              crc_present;
		logic              padding;
		logic [1:0]        channel_mode;
		logic [1:0]        mode_extension;
		logic [1:0]        channels;
		logic [3:0]        misc_bits;
		logic [BR_W-1:0]   bitrate_kbps;
		logic [FS_W-1:0]   sample_rate_hz;
	} hdr_t;

	// operands of the length divide
	typedef struct packed {
		logic [COEF_W-1:0]  coef;
		logic [SHIFT_W-1:0] shift;
		logic [RECIP_W-1:0] recip;
	} scale_t;

	// bitrate tables in kbps, index 0 and 15 read as zero
	localparam logic [BR_W-1:0] BR_V1_L1 [16] = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam logic [BR_W-1:0] BR_V1_L2 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam logic [BR_W-1:0] BR_V1_L3 [16] = '{
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam logic [BR_W-1:0] BR_V2_L1 [16] = '{
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam logic [BR_W-1:0] BR_V2_L23 [16] = '{
		9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	function automatic logic [BR_W-1:0] br_lookup(input logic [2:0] grp, input logic [3:0] idx);
		logic [BR_W-1:0] br;
		unique case (grp)
			GRP_V1_L1:  br = BR_V1_L1[idx];
			GRP_V1_L2:  br = BR_V1_L2[idx];
			GRP_V1_L3:  br = BR_V1_L3[idx];
			GRP_V2_L1:  br = BR_V2_L1[idx];
			GRP_V2_L23: br = BR_V2_L23[idx];
			default:    br = '0;
		endcase
		return br;
	endfunction

	// sample rate in hz, halved per version step
	function automatic logic [FS_W-1:0] fs_lookup(input logic [1:0] ver, input logic [1:0] fsi);
		logic [FS_W-1:0] base;
		unique case (fsi)
			FSI_44:  base = FS_W'(FS_44K1);
			FSI_48:  base = FS_W'(FS_48K);
			FSI_32:  base = FS_W'(FS_32K);
			default: base = '0;
		endcase
		return base >> ver;
	endfunction

endpackage

@@ rtl/core/mafhd_decode.sv @@
// first pipeline stage: sync and field checks, table lookups, divide operands
module mafhd_decode import mafhd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] header_word,
	output logic        out_valid,
	input  logic        out_ready,
	output hdr_t        out_hdr,
	output scale_t      out_scale
);

	logic       valid_s1;
	hdr_t       hdr_s1;
	scale_t     scale_s1;
	logic [1:0] vbits;
	logic [1:0] lbits;
	logic [3:0] bri;
	logic [1:0] fsi;
	logic [1:0] ver;
	logic [1:0] lay;
	logic [2:0] grp;
	logic [BR_W-1:0] br;
	status_t    st;
	hdr_t       hdr_d;
	scale_t     scale_d;

	assign vbits = header_word[20:19];
	assign lbits = header_word[18:17];
	assign bri   = header_word[15:12];
	assign fsi   = header_word[11:10];

	// version, layer and bitrate group
	always_comb begin
		unique case (vbits)
			HV_MPEG1: ver = VER_MPEG1;
			HV_MPEG2: ver = VER_MPEG2;
			default:  ver = VER_MPEG25;
		endcase
		lay = 2'd3 - lbits;
		if (ver == VER_MPEG1) begin
			grp = {1'b0, lay};
		end else if (lay == LAYER_I) begin
			grp = GRP_V2_L1;
		end else begin
			grp = GRP_V2_L23;
		end
		br = br_lookup(grp, bri);
	end

	// first failing check sets the status
	always_comb begin
		priority if (header_word[31:21] != SYNC_MARK) begin
			st = ST_NO_SYNC;
		end else if (vbits == HV_RESERVED) begin
			st = ST_BAD_VERSION;
		end else if (lbits == HL_RESERVED) begin
			st = ST_BAD_LAYER;
		end else if (br == '0) begin
			st = ST_BAD_BITRATE;
		end else if (fsi == FSI_RESERVED) begin
			st = ST_BAD_RATE;
		end else begin
			st = ST_OK;
		end
	end

	// result fields and divide operands, all zero but the status on error
	always_comb begin
		hdr_d.status         = st;
		hdr_d.mpeg_version   = ver;
		hdr_d.layer_index    = lay;
		hdr_d.crc_present    = ~header_word[16];
		hdr_d.padding        = header_word[9];
		hdr_d.channel_mode   = header_word[7:6];
		hdr_d.mode_extension = header_word[5:4];
		hdr_d.channels       = (header_word[7:6] == CHMODE_MONO) ? 2'd1 : 2'd2;
		hdr_d.misc_bits      = header_word[3:0];
		hdr_d.bitrate_kbps   = br;
		hdr_d.sample_rate_hz = fs_lookup(ver, fsi);

		unique case (fsi)
			FSI_44: begin
				scale_d.coef  = (lay == LAYER_I) ? COEF_W'(A_L1_44) : COEF_W'(A_L23_44);
				scale_d.recip = (lay == LAYER_I) ? RECIP_W'(R_L1_44) : RECIP_W'(R_L23_44);
			end
			FSI_48: begin
				scale_d.coef  = (lay == LAYER_I) ? COEF_W'(A_L1_48) : COEF_W'(A_L23_48);
				scale_d.recip = (lay == LAYER_I) ? RECIP_W'(R_L1_48) : RECIP_W'(R_L23_48);
			end
			FSI_32: begin
				scale_d.coef  = (lay == LAYER_I) ? COEF_W'(A_L1_32) : COEF_W'(A_L23_32);
				scale_d.recip = (lay == LAYER_I) ? RECIP_W'(R_L1_32) : RECIP_W'(R_L23_32);
			end
			default: begin
				scale_d.coef  = '0;
				scale_d.recip = '0;
			end
		endcase
		// lower versions halve fs, layer iii there also doubles the divisor
		if (lay == LAYER_III && ver != VER_MPEG1) begin
			scale_d.shift = ver - 2'd1;
		end else begin
			scale_d.shift = ver;
		end

		if (st != ST_OK) begin
			hdr_d        = '0;
			hdr_d.status = st;
			scale_d      = '0;
		end
	end

	assign in_ready = ~valid_s1 | out_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hdr_s1   <= hdr_d;
			scale_s1 <= scale_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_hdr   = hdr_s1;
	assign out_scale = scale_s1;

endmodule

@@ rtl/core/mafhd_scale.sv @@
// second and third pipeline stages: coef*bitrate product, then reciprocal multiply
module mafhd_scale import mafhd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hdr_t              in_hdr,
	input  scale_t            in_scale,
	output logic              out_valid,
	input  logic              out_ready,
	output hdr_t              out_hdr,
	output logic [WIDE_W-1:0] out_wide
);

	logic                 valid_s2;
	hdr_t                 hdr_s2;
	logic [PROD_W-1:0]    prod_s2;
	logic [RECIP_W-1:0]   recip_s2;
	logic                 valid_s3;
	hdr_t                 hdr_s3;
	logic [WIDE_W-1:0]    wide_s3;
	logic                 ready_s3;
	logic [COEF_W+BR_W-1:0] ab;
	logic [PROD_W-1:0]    prod_d;
	logic [WIDE_W-1:0]    wide_d;

	// numerator: coef * bitrate, scaled by the version shift
	assign ab     = in_scale.coef * in_hdr.bitrate_kbps;
	assign prod_d = PROD_W'(ab) << in_scale.shift;

	// quotient in the upper bits of the reciprocal product
	assign wide_d = WIDE_W'(prod_s2) * WIDE_W'(recip_s2);

	assign ready_s3 = ~valid_s3 | out_ready;
	assign in_ready = ~valid_s2 | ready_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hdr_s2   <= in_hdr;
			prod_s2  <= prod_d;
			recip_s2 <= in_scale.recip;
		end
		if (ready_s3 && valid_s2) begin
			hdr_s3  <= hdr_s2;
			wide_s3 <= wide_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_hdr   = hdr_s3;
	assign out_wide  = wide_s3;

endmodule

@@ rtl/core/mafhd_finish.sv @@
// last pipeline stage: frame length, saturation and the output register
module mafhd_finish import mafhd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hdr_t              in_hdr,
	input  logic [WIDE_W-1:0] in_wide,
	output logic              out_valid,
	input  logic              out_ready,
	output hdr_t              out_hdr,
	output logic [LEN_W-1:0]  out_len
);

	logic               valid_s4;
	hdr_t               hdr_s4;
	logic [LEN_W-1:0]   len_s4;
	logic [QUOT_W-1:0]  quot;
	logic [LSUM_W-1:0]  slots;
	logic [LSUM_W-1:0]  bytes;
	logic [LSUM_W-1:0]  len_full;
	logic [LEN_W-1:0]   len_d;

	// slots plus padding, four bytes a slot for layer i, minus the header
	always_comb begin
		quot     = in_wide[WIDE_W-1:RECIP_SHIFT];
		slots    = LSUM_W'(quot) + LSUM_W'(in_hdr.padding);
		bytes    = (in_hdr.layer_index == LAYER_I) ? (slots << 2) : slots;
		len_full = bytes - LSUM_W'(4);
		if (in_hdr.status != ST_OK) begin
			len_d = '0;
		end else if (len_full > LSUM_W'(PAYLOAD_MAX)) begin
			len_d = LEN_W'(PAYLOAD_MAX);
		end else begin
			len_d = len_full[LEN_W-1:0];
		end
	end

	assign in_ready = ~valid_s4 | out_ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hdr_s4 <= in_hdr;
			len_s4 <= len_d;
		end
	end

	assign out_valid = valid_s4;
	assign out_hdr   = hdr_s4;
	assign out_len   = len_s4;

endmodule

@@ rtl/core/mpeg_audio_frame_header_decode_unit.sv @@
// top level of the mpeg audio frame header decoder: four-stage pipeline
//
// channel | signals                                   | role
// --------+-------------------------------------------+----------------------------
// in      | in_valid, in_ready, header_word           | one 32-bit header per item
// out     | out_valid, out_ready, status .. payload_bytes | decoded fields per item
//
// one item per cycle sustained while out_ready is high. an accepted item moves
// through the stage registers in order (decode, product, reciprocal multiply,
// length); out_valid rises once it is in the length stage. the two multiplies
// set the depth. every stage takes a new item when it is empty or its successor
// moves, so bubbles close up and a stall at out_ready holds all stages in place.
// reset clears the stage valid bits only; the payload registers are not reset.
module mpeg_audio_frame_header_decode_unit import mafhd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] header_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  mpeg_version,
	output logic [1:0]  layer_index,
	output logic        crc_present,
	output logic        padding,
	output logic [1:0]  channel_mode,
	output logic [1:0]  mode_extension,
	output logic [1:0]  channels,
	output logic [3:0]  misc_bits,
	output logic [8:0]  bitrate_kbps,
	output logic [15:0] sample_rate_hz,
	output logic [10:0] payload_bytes
);

	logic              dec_valid;
	logic              dec_ready;
	hdr_t              dec_hdr;
	scale_t            dec_scale;
	logic              scl_valid;
	logic              scl_ready;
	hdr_t              scl_hdr;
	logic [WIDE_W-1:0] scl_wide;
	hdr_t              fin_hdr;

	// decode and lookups
	mafhd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.header_word (header_word),
		.out_valid   (dec_valid),
		.out_ready   (dec_ready),
		.out_hdr     (dec_hdr),
		.out_scale   (dec_scale)
	);

	// divide by the sample rate through a reciprocal multiply
	mafhd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_hdr    (dec_hdr),
		.in_scale  (dec_scale),
		.out_valid (scl_valid),
		.out_ready (scl_ready),
		.out_hdr   (scl_hdr),
		.out_wide  (scl_wide)
	);

	// frame length and output register
	mafhd_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.in_hdr    (scl_hdr),
		.in_wide   (scl_wide),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_hdr   (fin_hdr),
		.out_len   (payload_bytes)
	);

	assign status         = fin_hdr.status;
	assign mpeg_version   = fin_hdr.mpeg_version;
	assign layer_index    = fin_hdr.layer_index;
	assign crc_present    = fin_hdr.crc_present;
	assign padding        = fin_hdr.padding;
	assign channel_mode   = fin_hdr.channel_mode;
	assign mode_extension = fin_hdr.mode_extension;
	assign channels       = fin_hdr.channels;
	assign misc_bits      = fin_hdr.misc_bits;
	assign bitrate_kbps   = fin_hdr.bitrate_kbps;
	assign sample_rate_hz = fin_hdr.sample_rate_hz;

	// error results carry no rates and no length
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(payload_bytes == '0 && bitrate_kbps == '0 && sample_rate_hz == '0))
		else $error("error item carries nonzero payload");

	// good results always have both rates and a nonzero length
	a_ok_rates: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |->
		(bitrate_kbps != '0 && sample_rate_hz != '0 && payload_bytes != '0))
		else $error("good item missing bitrate, rate or length");

	// channel count follows channel mode on good results
	a_channels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |->
		(channels == ((channel_mode == CHMODE_MONO) ? 2'd1 : 2'd2)))
		else $error("channel count does not match channel mode");

	// a stalled output stage must not take a new item from the middle stage
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !scl_ready)
		else $error("last stage accepts while its result is stalled");

endmodule
